// File: rtl/earliest_finish_server_dispatcher_assert.svh
// assertion macros shared by the dispatcher modules
`ifndef EARLIEST_FINISH_SERVER_DISPATCHER_ASSERT_SVH
`define EARLIEST_FINISH_SERVER_DISPATCHER_ASSERT_SVH

`ifndef ASSERT_OFF

`define EFSD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("dispatcher assertion failed");

`define EFSD_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dispatcher assertion failed");

`else

`define EFSD_ASSERT(label, prop)

`define EFSD_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

// File: rtl/efsd_pkg.sv
package efsd_pkg;

   localparam int DUR_W  = 30;
   localparam int TIME_W = 62;

   typedef logic [DUR_W-1:0]  dur_type;
   typedef logic [TIME_W-1:0] time_type;

   localparam time_type TIME_TOP = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_ADD      = 2'd1,
      OP_DISPATCH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_FRONT = 2'd0,
      RD_PREV  = 2'd1,
      RD_NEXT  = 2'd2
   } rd_sel_type;

   typedef struct packed {
      dur_type  dur;
      time_type fin;
      time_type nxt;
   } slot_type;

   typedef struct packed {
      logic       load_clear;
      logic       load_add;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       front_calc;
      logic       next_calc;
      logic       shift_wr;
      logic       shift_down;
      logic       place_wr;
      logic       cnt_inc;
      logic       max_upd;
      logic       resp_load;
      logic       resp_dispatch;
      status_type resp_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic ptr_zero;
      logic ptr_last;
      logic rd_after;
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_CHK,
      S_INS_CMP,
      S_INS_PLACE,
      S_DSP_FRONT,
      S_DSP_NEXT,
      S_DSP_CHK,
      S_DSP_CMP,
      S_DSP_PLACE
   } state_type;

endpackage

// File: rtl/efsd_req_if.sv
interface efsd_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   efsd_pkg::dur_type server_duration_in;

   modport source (output valid, output operation, output server_duration_in, input ready);
   modport sink (input valid, input operation, input server_duration_in, output ready);
endinterface

// File: rtl/efsd_rsp_if.sv
interface efsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   efsd_pkg::time_type finish_time;
   efsd_pkg::dur_type  chosen_duration;
   efsd_pkg::time_type max_finish;

   modport source (output valid, output status, output finish_time, output chosen_duration,
                   output max_finish, input ready);
   modport sink (input valid, input status, input finish_time, input chosen_duration,
                 input max_finish, output ready);
endinterface

// File: rtl/earliest_finish_server_dispatcher.sv
// earliest finish server dispatcher
// keeps an ordered list of servers (duration, last finish) sorted by next
// finish, ties by smaller duration, in a one-write-port memory of MAX_SERVERS
// entries. req_bus carries operation and server_duration_in; rsp_bus returns
// status, finish_time, chosen_duration and max_finish, one transfer per item.
// clear, a full add, an empty dispatch and unused codes answer from idle.
// add: each server that orders after the new one is read (S_INS_CHK) and
// moved one place back (S_INS_CMP), then the new one is written (S_INS_PLACE).
// dispatch: the front's finish and next finish are formed (S_DSP_FRONT,
// S_DSP_NEXT), each server it moves past is read and moved one place forward
// (S_DSP_CHK, S_DSP_CMP), then it is written back (S_DSP_PLACE). the ordered
// shift is one memory read and one write per entry; one item is in flight at a time.
// results sit in an output register; req_bus.ready is high in idle while that
// register is empty or is being taken. a stalled rsp_bus holds the result and
// blocks new items until the transfer completes.
// reset clears the server count and the running maximum; the memory is not
// cleared, no entry beyond the count is ever read.
module earliest_finish_server_dispatcher #(
   parameter int MAX_SERVERS = 64
) (
   input logic         clock,
   input logic         reset,
   efsd_req_if.sink    req_bus,
   efsd_rsp_if.source  rsp_bus
);

   efsd_pkg::cmd_type    cmd;
   efsd_pkg::stat_type   stat;
   efsd_pkg::status_type rsp_status;

   efsd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_op    (req_bus.operation),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   efsd_datapath #(
      .MAX_SERVERS (MAX_SERVERS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_dur      (req_bus.server_duration_in),
      .stat         (stat),
      .rsp_status   (rsp_status),
      .rsp_finish   (rsp_bus.finish_time),
      .rsp_duration (rsp_bus.chosen_duration),
      .rsp_max      (rsp_bus.max_finish)
   );

   assign rsp_bus.status = rsp_status;

endmodule

// File: rtl/efsd_datapath.sv
`include "earliest_finish_server_dispatcher_assert.svh"

module efsd_datapath #(
   parameter int MAX_SERVERS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  efsd_pkg::cmd_type     cmd,
   input  efsd_pkg::dur_type     req_dur,
   output efsd_pkg::stat_type    stat,
   output efsd_pkg::status_type  rsp_status,
   output efsd_pkg::time_type    rsp_finish,
   output efsd_pkg::dur_type     rsp_duration,
   output efsd_pkg::time_type    rsp_max
);

   localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CW = $clog2(MAX_SERVERS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SERVERS);
   localparam logic [CW-1:0] ONE     = CW'(1);

   function automatic efsd_pkg::time_type sat_add(efsd_pkg::time_type a,
                                                  efsd_pkg::dur_type d);
      logic [efsd_pkg::TIME_W:0] s;
      s = {1'b0, a} + {{(efsd_pkg::TIME_W + 1 - efsd_pkg::DUR_W){1'b0}}, d};
      return s[efsd_pkg::TIME_W] ? efsd_pkg::TIME_TOP : s[efsd_pkg::TIME_W-1:0];
   endfunction

   efsd_pkg::slot_type mem [MAX_SERVERS];

   logic [CW-1:0]        cnt_ff, cnt_in;
   efsd_pkg::time_type   max_ff, max_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   efsd_pkg::slot_type   rec_ff, rec_in;
   efsd_pkg::slot_type   rd_ff;
   efsd_pkg::status_type rsp_status_ff, rsp_status_in;
   efsd_pkg::time_type   rsp_fin_ff, rsp_fin_in;
   efsd_pkg::dur_type    rsp_dur_ff, rsp_dur_in;
   efsd_pkg::time_type   rsp_max_ff, rsp_max_in;

   logic [CW-1:0] rd_ptr;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   always_comb begin
      case (cmd.rd_sel)
         efsd_pkg::RD_PREV: begin
            rd_ptr = ptr_ff - ONE;
         end
         efsd_pkg::RD_NEXT: begin
            rd_ptr = ptr_ff + ONE;
         end
         default: begin
            rd_ptr = '0;
         end
      endcase
   end

   assign rd_addr = rd_ptr[AW-1:0];
   assign wr_addr = ptr_ff[AW-1:0];

   always_comb begin
      cnt_in        = cnt_ff;
      max_in        = max_ff;
      ptr_in        = ptr_ff;
      rec_in        = rec_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_dur_in    = rsp_dur_ff;
      rsp_max_in    = rsp_max_ff;
      if (cmd.load_clear) begin
         cnt_in = '0;
         max_in = '0;
      end
      if (cmd.load_add) begin
         rec_in.dur = req_dur;
         rec_in.fin = '0;
         rec_in.nxt = {{(efsd_pkg::TIME_W - efsd_pkg::DUR_W){1'b0}}, req_dur};
         ptr_in     = cnt_ff;
      end
      if (cmd.front_calc) begin
         rec_in.dur = rd_ff.dur;
         rec_in.fin = sat_add(rd_ff.fin, rd_ff.dur);
      end
      if (cmd.next_calc) begin
         rec_in.nxt = sat_add(rec_ff.fin, rec_ff.dur);
         ptr_in     = '0;
      end
      if (cmd.shift_wr) begin
         ptr_in = cmd.shift_down ? ptr_ff - ONE : ptr_ff + ONE;
      end
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + ONE;
      end
      if (cmd.max_upd && (rec_ff.fin > max_ff)) begin
         max_in = rec_ff.fin;
      end
      if (cmd.resp_load) begin
         rsp_status_in = cmd.resp_status;
         rsp_fin_in    = cmd.resp_dispatch ? rec_ff.fin : '0;
         rsp_dur_in    = cmd.resp_dispatch ? rec_ff.dur : '0;
         rsp_max_in    = max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         max_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rec_ff        <= rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_dur_ff    <= rsp_dur_in;
      rsp_max_ff    <= rsp_max_in;
   end

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (cmd.shift_wr) begin
         mem[wr_addr] <= rd_ff;
      end else if (cmd.place_wr) begin
         mem[wr_addr] <= rec_ff;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      stat.full     = (cnt_ff == CNT_MAX);
      stat.empty    = (cnt_ff == '0);
      stat.ptr_zero = (ptr_ff == '0);
      stat.ptr_last = ((ptr_ff + ONE) == cnt_ff);
      if (rd_ff.nxt != rec_ff.nxt) begin
         stat.rd_after = (rd_ff.nxt > rec_ff.nxt);
      end else begin
         stat.rd_after = (rd_ff.dur > rec_ff.dur);
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_finish   = rsp_fin_ff;
   assign rsp_duration = rsp_dur_ff;
   assign rsp_max      = rsp_max_ff;

   `EFSD_ASSERT_IMPLY(a_insert_room, cmd.cnt_inc, cnt_ff < CNT_MAX)
   `EFSD_ASSERT_IMPLY(a_shift_down_range, cmd.shift_wr && cmd.shift_down, ptr_ff != '0)
   `EFSD_ASSERT_IMPLY(a_max_grows, !$past(reset) && !$past(cmd.load_clear), max_ff >= $past(max_ff))

endmodule

// File: rtl/efsd_controller.sv
`include "earliest_finish_server_dispatcher_assert.svh"

module efsd_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  efsd_pkg::stat_type stat,
   output efsd_pkg::cmd_type  cmd
);

   efsd_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   efsd_pkg::op_type    op;

   assign op        = efsd_pkg::op_type'(req_op);
   assign req_ready = (state_ff == efsd_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         efsd_pkg::S_IDLE: begin
            if (accept) begin
               case (op)
                  efsd_pkg::OP_ADD: begin
                     if (!stat.full) state_in = efsd_pkg::S_INS_CHK;
                  end
                  efsd_pkg::OP_DISPATCH: begin
                     if (!stat.empty) state_in = efsd_pkg::S_DSP_FRONT;
                  end
                  default: begin
                     state_in = efsd_pkg::S_IDLE;
                  end
               endcase
            end
         end
         efsd_pkg::S_INS_CHK: begin
            state_in = stat.ptr_zero ? efsd_pkg::S_INS_PLACE : efsd_pkg::S_INS_CMP;
         end
         efsd_pkg::S_INS_CMP: begin
            state_in = stat.rd_after ? efsd_pkg::S_INS_CHK : efsd_pkg::S_INS_PLACE;
         end
         efsd_pkg::S_DSP_FRONT: begin
            state_in = efsd_pkg::S_DSP_NEXT;
         end
         efsd_pkg::S_DSP_NEXT: begin
            state_in = efsd_pkg::S_DSP_CHK;
         end
         efsd_pkg::S_DSP_CHK: begin
            state_in = stat.ptr_last ? efsd_pkg::S_DSP_PLACE : efsd_pkg::S_DSP_CMP;
         end
         efsd_pkg::S_DSP_CMP: begin
            state_in = stat.rd_after ? efsd_pkg::S_DSP_PLACE : efsd_pkg::S_DSP_CHK;
         end
         default: begin
            state_in = efsd_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.rd_sel      = efsd_pkg::RD_FRONT;
      cmd.resp_status = efsd_pkg::ST_OK;
      case (state_ff)
         efsd_pkg::S_IDLE: begin
            if (accept) begin
               case (op)
                  efsd_pkg::OP_CLEAR: begin
                     cmd.load_clear = 1'b1;
                     cmd.resp_load  = 1'b1;
                  end
                  efsd_pkg::OP_ADD: begin
                     if (stat.full) begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_status = efsd_pkg::ST_FULL;
                     end else begin
                        cmd.load_add = 1'b1;
                     end
                  end
                  efsd_pkg::OP_DISPATCH: begin
                     if (stat.empty) begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_status = efsd_pkg::ST_EMPTY;
                     end else begin
                        cmd.rd_en = 1'b1;
                     end
                  end
                  default: begin
                     cmd.resp_load = 1'b1;
                  end
               endcase
            end
         end
         efsd_pkg::S_INS_CHK: begin
            if (!stat.ptr_zero) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = efsd_pkg::RD_PREV;
            end
         end
         efsd_pkg::S_INS_CMP: begin
            if (stat.rd_after) begin
               cmd.shift_wr   = 1'b1;
               cmd.shift_down = 1'b1;
            end
         end
         efsd_pkg::S_INS_PLACE: begin
            cmd.place_wr  = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.resp_load = 1'b1;
         end
         efsd_pkg::S_DSP_FRONT: begin
            cmd.front_calc = 1'b1;
         end
         efsd_pkg::S_DSP_NEXT: begin
            cmd.next_calc = 1'b1;
         end
         efsd_pkg::S_DSP_CHK: begin
            if (!stat.ptr_last) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = efsd_pkg::RD_NEXT;
            end
         end
         efsd_pkg::S_DSP_CMP: begin
            if (!stat.rd_after) begin
               cmd.shift_wr = 1'b1;
            end
         end
         efsd_pkg::S_DSP_PLACE: begin
            cmd.place_wr      = 1'b1;
            cmd.max_upd       = 1'b1;
            cmd.resp_load     = 1'b1;
            cmd.resp_dispatch = 1'b1;
         end
         default: begin
            cmd.resp_status = efsd_pkg::ST_OK;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.resp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efsd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `EFSD_ASSERT(a_accept_busy, accept |=> (state_ff != efsd_pkg::S_IDLE) || rsp_valid_ff)
   `EFSD_ASSERT_IMPLY(a_load_free, cmd.resp_load, !rsp_valid_ff || rsp_ready)
   `EFSD_ASSERT_IMPLY(a_busy_no_rsp, state_ff != efsd_pkg::S_IDLE, !rsp_valid_ff)

endmodule

// File: test/earliest_finish_server_dispatcher_test.sv
`timescale 1ns / 1ps

module earliest_finish_server_dispatcher_test;

   localparam int SERVER_SLOTS = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_CYCLES = 2 * SERVER_SLOTS + 20;
   localparam int RANDOM_ITEMS = 1350;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam efsd_pkg::dur_type DUR_TOP = {efsd_pkg::DUR_W{1'b1}};

   typedef struct {
      logic [1:0]         status;
      efsd_pkg::time_type finish;
      efsd_pkg::dur_type  duration;
      efsd_pkg::time_type max_finish;
   } result_type;

   logic clock;
   logic reset;

   efsd_req_if req_bus();
   efsd_rsp_if rsp_bus();

   earliest_finish_server_dispatcher #(
      .MAX_SERVERS(SERVER_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // predicted server list, ordered by next finish then duration
   efsd_pkg::dur_type  srv_duration [SERVER_SLOTS];
   efsd_pkg::time_type srv_finish [SERVER_SLOTS];
   efsd_pkg::time_type srv_next [SERVER_SLOTS];
   int                 srv_count;
   efsd_pkg::time_type srv_max_finish;

   result_type expected_results[$];
   result_type got_result;
   int         mismatch_count;
   int         sent_count;
   int         burst_left;
   int         idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic efsd_pkg::time_type add_saturated(efsd_pkg::time_type a,
                                                        efsd_pkg::time_type b);
      logic [efsd_pkg::TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return (sum > {1'b0, efsd_pkg::TIME_TOP}) ? efsd_pkg::TIME_TOP
                                                : sum[efsd_pkg::TIME_W-1:0];
   endfunction

   function automatic bit orders_after(efsd_pkg::time_type na, efsd_pkg::dur_type da,
                                       efsd_pkg::time_type nb, efsd_pkg::dur_type db);
      if (na != nb)
         return na > nb;
      return da > db;
   endfunction

   function automatic void insert_server(efsd_pkg::dur_type d, efsd_pkg::time_type f,
                                         efsd_pkg::time_type n);
      int pos;
      pos = 0;
      while (pos < srv_count && !orders_after(srv_next[pos], srv_duration[pos], n, d))
         pos++;
      for (int k = srv_count; k > pos; k--) begin
         srv_duration[k] = srv_duration[k-1];
         srv_finish[k] = srv_finish[k-1];
         srv_next[k] = srv_next[k-1];
      end
      srv_duration[pos] = d;
      srv_finish[pos] = f;
      srv_next[pos] = n;
      srv_count++;
   endfunction

   function automatic result_type predict_dispatch(logic [1:0] op, efsd_pkg::dur_type d_in);
      result_type r;
      efsd_pkg::dur_type d;
      efsd_pkg::time_type f;
      r.status = efsd_pkg::ST_OK;
      r.finish = '0;
      r.duration = '0;
      if (op == efsd_pkg::OP_CLEAR) begin
         srv_count = 0;
         srv_max_finish = '0;
      end else if (op == efsd_pkg::OP_ADD) begin
         if (srv_count >= SERVER_SLOTS)
            r.status = efsd_pkg::ST_FULL;
         else
            insert_server(d_in, '0, efsd_pkg::time_type'(d_in));
      end else if (op == efsd_pkg::OP_DISPATCH) begin
         if (srv_count == 0) begin
            r.status = efsd_pkg::ST_EMPTY;
         end else begin
            d = srv_duration[0];
            f = add_saturated(srv_finish[0], efsd_pkg::time_type'(d));
            for (int k = 1; k < srv_count; k++) begin
               srv_duration[k-1] = srv_duration[k];
               srv_finish[k-1] = srv_finish[k];
               srv_next[k-1] = srv_next[k];
            end
            srv_count--;
            insert_server(d, f, add_saturated(f, efsd_pkg::time_type'(d)));
            if (f > srv_max_finish)
               srv_max_finish = f;
            r.finish = f;
            r.duration = d;
         end
      end
      r.max_finish = srv_max_finish;
      return r;
   endfunction

   task automatic report_mismatch(string what, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch (%s): expected st %0d fin %0d dur %0d max %0d",
                  what, want.status, want.finish, want.duration, want.max_finish);
         $display("   got st %0d fin %0d dur %0d max %0d",
                  got.status, got.finish, got.duration, got.max_finish);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_result.status = rsp_bus.status;
         got_result.finish = rsp_bus.finish_time;
         got_result.duration = rsp_bus.chosen_duration;
         got_result.max_finish = rsp_bus.max_finish;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", '{default: '0}, got_result);
         end else begin
            if (got_result.status !== expected_results[0].status ||
                got_result.finish !== expected_results[0].finish ||
                got_result.duration !== expected_results[0].duration ||
                got_result.max_finish !== expected_results[0].max_finish)
               report_mismatch("field", expected_results[0], got_result);
            void'(expected_results.pop_front());
         end
      end
   end

   // receiver stall pattern
   initial begin
      int mode;
      int span;
      int phase;
      rsp_bus.ready <= 1'b0;
      phase = 0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 300);
         repeat (span) begin
            @(posedge clock);
            phase++;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= (phase % 7) < 4;
            endcase
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("earliest_finish_server_dispatcher_test: FAIL");
      $finish;
   end

   task automatic send_item(logic [1:0] op, efsd_pkg::dur_type d);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.server_duration_in <= d;
      do
         @(posedge clock);
      while (!req_bus.ready);
      expected_results.push_back(predict_dispatch(op, d));
      sent_count++;
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic efsd_pkg::dur_type pick_duration();
      case ($urandom_range(0, 5))
         0: return efsd_pkg::dur_type'($urandom_range(0, 3));
         1, 2: return efsd_pkg::dur_type'($urandom_range(0, 12));
         3: return efsd_pkg::dur_type'($urandom_range(0, 1000));
         4: return ($urandom_range(0, 1) == 0) ? '0 : DUR_TOP;
         default: return efsd_pkg::dur_type'($urandom());
      endcase
   endfunction

   task automatic test_empty_and_unused();
      send_item(efsd_pkg::OP_DISPATCH, DUR_TOP);
      send_item(OP_UNUSED, '0);
      send_item(efsd_pkg::OP_ADD, 30'd7);
      send_item(OP_UNUSED, DUR_TOP);
      send_item(efsd_pkg::OP_CLEAR, DUR_TOP);
      send_item(efsd_pkg::OP_DISPATCH, '0);
   endtask

   task automatic test_extremes_and_ties();
      send_item(efsd_pkg::OP_ADD, '0);
      send_item(efsd_pkg::OP_ADD, DUR_TOP);
      send_item(efsd_pkg::OP_ADD, DUR_TOP);
      send_item(efsd_pkg::OP_DISPATCH, '0);
      send_item(efsd_pkg::OP_DISPATCH, '0);
      send_item(efsd_pkg::OP_CLEAR, '0);
      // equal next finish, smaller duration goes first
      send_item(efsd_pkg::OP_ADD, 30'd2);
      send_item(efsd_pkg::OP_ADD, 30'd1);
      send_item(efsd_pkg::OP_ADD, 30'd2);
      repeat (5) send_item(efsd_pkg::OP_DISPATCH, DUR_TOP);
      send_item(efsd_pkg::OP_ADD, DUR_TOP);
      repeat (4) send_item(efsd_pkg::OP_DISPATCH, '0);
      send_item(efsd_pkg::OP_CLEAR, '0);
   endtask

   task automatic test_table_full();
      send_item(efsd_pkg::OP_CLEAR, '0);
      repeat (SERVER_SLOTS) send_item(efsd_pkg::OP_ADD, pick_duration());
      send_item(efsd_pkg::OP_ADD, DUR_TOP);
      send_item(efsd_pkg::OP_ADD, '0);
      repeat (30) send_item(efsd_pkg::OP_DISPATCH, '0);
      send_item(efsd_pkg::OP_ADD, 30'd5);
      wait_for_drain();
      send_item(efsd_pkg::OP_CLEAR, '0);
   endtask

   task automatic test_random_traffic();
      int n;
      bit paused;
      paused = 0;
      while (sent_count < RANDOM_ITEMS) begin
         if (!paused && sent_count > RANDOM_ITEMS / 2) begin
            wait_for_drain();
            paused = 1;
         end
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(0, 3)), efsd_pkg::dur_type'($urandom()));
         end else begin
            if ($urandom_range(0, 2) != 0)
               send_item(efsd_pkg::OP_CLEAR, efsd_pkg::dur_type'($urandom()));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
            repeat (n) send_item(efsd_pkg::OP_ADD, pick_duration());
            repeat ($urandom_range(1, 3 * n + 5)) begin
               if ($urandom_range(0, 9) == 0)
                  send_item(efsd_pkg::OP_ADD, pick_duration());
               else
                  send_item(efsd_pkg::OP_DISPATCH, efsd_pkg::dur_type'($urandom()));
            end
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= efsd_pkg::OP_CLEAR;
      req_bus.server_duration_in <= '0;
      srv_count = 0;
      srv_max_finish = '0;
      mismatch_count = 0;
      sent_count = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_unused();
      test_extremes_and_ties();
      test_table_full();
      test_random_traffic();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("earliest_finish_server_dispatcher_test: PASS");
      else
         $display("earliest_finish_server_dispatcher_test: FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/efsd_pkg.sv
rtl/efsd_req_if.sv
rtl/efsd_rsp_if.sv
rtl/efsd_datapath.sv
rtl/efsd_controller.sv
rtl/earliest_finish_server_dispatcher.sv
test/earliest_finish_server_dispatcher_test.sv
